// ===== sv/rbm_pkg.sv =====
`timescale 1ns / 1ps

package rbm_pkg;

  // Channel geometry.
  localparam int unsigned ChanW   = 16;
  localparam int unsigned NumChan = 3;
  localparam int unsigned OpW     = 3;

  // Channel ceiling.
  localparam logic [ChanW-1:0] ChanMax = 16'hFFFF;

  // Mode codes.
  localparam logic [OpW-1:0] OP_ADD     = 3'd0;
  localparam logic [OpW-1:0] OP_SUB     = 3'd1;
  localparam logic [OpW-1:0] OP_OVERLAY = 3'd2;
  localparam logic [OpW-1:0] OP_SCREEN  = 3'd3;
  localparam logic [OpW-1:0] OP_AVERAGE = 3'd4;

  // One blend request.
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ChanW-1:0] first_red;
    logic [ChanW-1:0] first_green;
    logic [ChanW-1:0] first_blue;
    logic [ChanW-1:0] second_red;
    logic [ChanW-1:0] second_green;
    logic [ChanW-1:0] second_blue;
    logic [ChanW-1:0] mix_factor;
  } blend_req_t;

  // One blended colour.
  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
  } blend_rsp_t;

  // Crossfaded channels, index 0 red, 1 green, 2 blue.
  typedef struct packed {
    logic [OpW-1:0]                  op;
    logic [NumChan-1:0][ChanW-1:0]   a;
    logic [NumChan-1:0][ChanW-1:0]   b;
  } xfade_t;

  // Crossfaded channels plus the overlay threshold bit and the mode product of each channel.
  typedef struct packed {
    logic [OpW-1:0]                  op;
    logic [NumChan-1:0][ChanW-1:0]   a;
    logic [NumChan-1:0][ChanW-1:0]   b;
    logic [NumChan-1:0]              upper;
    logic [NumChan-1:0][2*ChanW-1:0] prod;
  } prod_t;

endpackage

// ===== sv/rbm_xfade.sv =====
`timescale 1ns / 1ps

module rbm_xfade
  import rbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  blend_req_t req_i,
  output logic       valid_o,
  output xfade_t     data_o
);

  logic [NumChan-1:0][ChanW-1:0] first_w;
  logic [NumChan-1:0][ChanW-1:0] second_w;
  logic [ChanW-1:0]              twice_f;
  logic [ChanW-1:0]              gain;
  logic                          fade_first;
  xfade_t                        data_d;
  xfade_t                        data_q;
  logic                          valid_q;

  assign first_w  = {req_i.first_blue, req_i.first_green, req_i.first_red};
  assign second_w = {req_i.second_blue, req_i.second_green, req_i.second_red};

  // Upper half of the factor fades the first colour, lower half the second.
  // Both gains come from twice the factor with the top bit dropped.
  assign fade_first = req_i.mix_factor[ChanW-1];
  assign twice_f    = {req_i.mix_factor[ChanW-2:0], 1'b0};
  assign gain       = fade_first ? ~twice_f : twice_f;

  // One 16 by 16 multiplier per channel scales the faded colour.
  always_comb begin
    logic [2*ChanW-1:0] scaled;
    data_d.op = req_i.op;
    for (int i = 0; i < NumChan; i++) begin
      scaled = {{ChanW{1'b0}}, gain} *
               {{ChanW{1'b0}}, (fade_first ? first_w[i] : second_w[i])};
      data_d.a[i] = fade_first ? scaled[2*ChanW-1:ChanW] : first_w[i];
      data_d.b[i] = fade_first ? second_w[i] : scaled[2*ChanW-1:ChanW];
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/rbm_mode_mul.sv =====
`timescale 1ns / 1ps

module rbm_mode_mul
  import rbm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  xfade_t data_i,
  output logic   valid_o,
  output prod_t  data_o
);

  prod_t data_d;
  prod_t data_q;
  logic  valid_q;

  // Overlay multiplies the channels directly below the threshold and their
  // complements above it; screen always multiplies the complements.
  always_comb begin
    logic [ChanW-1:0] x;
    logic [ChanW-1:0] y;
    logic             use_inv;
    data_d.op = data_i.op;
    data_d.a  = data_i.a;
    data_d.b  = data_i.b;
    for (int i = 0; i < NumChan; i++) begin
      use_inv = (data_i.op == OP_SCREEN) ||
                ((data_i.op == OP_OVERLAY) && data_i.a[i][ChanW-1]);
      x = use_inv ? ~data_i.a[i] : data_i.a[i];
      y = use_inv ? ~data_i.b[i] : data_i.b[i];
      data_d.upper[i] = data_i.a[i][ChanW-1];
      data_d.prod[i]  = {{ChanW{1'b0}}, x} * {{ChanW{1'b0}}, y};
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/rbm_resolve.sv =====
`timescale 1ns / 1ps

module rbm_resolve
  import rbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  prod_t      data_i,
  output logic       valid_o,
  output blend_rsp_t rsp_o
);

  logic [NumChan-1:0][ChanW-1:0] res_w;
  blend_rsp_t                    rsp_d;
  blend_rsp_t                    rsp_q;
  logic                          valid_q;

  // Per-channel mode result. Overlay divides twice the product by 65535:
  // with n = hi * 65536 + lo the quotient is hi, plus one when hi + lo
  // reaches 65535, since twice the product stays below 65535 * 65535.
  always_comb begin
    logic [2*ChanW:0]   twice;
    logic [ChanW:0]     hi;
    logic [ChanW+1:0]   rem_sum;
    logic [ChanW-1:0]   quot;
    logic [ChanW:0]     sum;
    for (int i = 0; i < NumChan; i++) begin
      twice   = {data_i.prod[i], 1'b0};
      hi      = twice[2*ChanW:ChanW];
      rem_sum = {1'b0, hi} + {2'b00, twice[ChanW-1:0]};
      quot    = hi[ChanW-1:0] + {{(ChanW-1){1'b0}}, (rem_sum >= {2'b00, ChanMax})};
      sum     = {1'b0, data_i.a[i]} + {1'b0, data_i.b[i]};
      case (data_i.op)
        OP_ADD:     res_w[i] = sum[ChanW-1:0];
        OP_SUB:     res_w[i] = ~data_i.a[i] - data_i.b[i];
        OP_OVERLAY: res_w[i] = data_i.upper[i] ? ~quot : quot;
        OP_SCREEN:  res_w[i] = ~data_i.prod[i][2*ChanW-1:ChanW];
        OP_AVERAGE: res_w[i] = sum[ChanW:1];
        default:    res_w[i] = '0;
      endcase
    end
  end

  assign rsp_d.out_red   = res_w[0];
  assign rsp_d.out_green = res_w[1];
  assign rsp_d.out_blue  = res_w[2];

  // Output register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

// ===== sv/rgb48_blend_mode_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_data_i  (blend_req_t)
// out       output     out_valid_o / out_ready_i  out_data_o (blend_rsp_t)
//
// Three register stages: crossfade multiply, mode multiply, then mode resolve
// with the divide by 65535. One transaction is taken every cycle unless the
// output stalls; the per-channel multipliers in the first two stages set
// the clock. Reset clears only the stage valid bits. A stalled output holds
// its transaction, and a stage accepts new data whenever it is empty or the
// stage after it moves, so bubbles are squeezed out during a stall.

module rgb48_blend_mode_unit
  import rbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  blend_req_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output blend_rsp_t out_data_o
);

  logic   xf_valid;
  logic   mul_valid;
  logic   en_xf;
  logic   en_mul;
  logic   en_out;
  xfade_t xf_data;
  prod_t  mul_data;

  // Each stage moves when it is empty or the stage after it moves.
  assign en_out     = !out_valid_o || out_ready_i;
  assign en_mul     = !mul_valid || en_out;
  assign en_xf      = !xf_valid || en_mul;
  assign in_ready_o = en_xf;

  // Crossfade of the two colours.
  rbm_xfade u_xfade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_xf),
    .valid_i (in_valid_i),
    .req_i   (in_data_i),
    .valid_o (xf_valid),
    .data_o  (xf_data)
  );

  // Overlay and screen products.
  rbm_mode_mul u_mode_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_mul),
    .valid_i (xf_valid),
    .data_i  (xf_data),
    .valid_o (mul_valid),
    .data_o  (mul_data)
  );

  // Mode selection and output register.
  rbm_resolve u_resolve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_out),
    .valid_i (mul_valid),
    .data_i  (mul_data),
    .valid_o (out_valid_o),
    .rsp_o   (out_data_o)
  );

endmodule

// ===== tb/sv/rgb48_blend_checker.sv =====
`timescale 1ns / 1ps

module rgb48_blend_checker
  import rbm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  blend_req_t  in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  blend_rsp_t  out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  // 64-bit copies of the channel ceiling and the crossfade midpoint, and the midpoint at channel width.
  localparam bit [63:0]        ChanTop = 64'(ChanMax);
  localparam bit [63:0]        HalfTop = 64'd32768;
  localparam logic [ChanW-1:0] MixMid  = 16'd32768;

  blend_rsp_t  expected_colour_q[$];
  int unsigned fail_count;
  int unsigned checked_count;
  string       chan_name[NumChan] = '{"out_red", "out_green", "out_blue"};

  assign fail_count_o = fail_count;
  assign pending_o    = expected_colour_q.size();
  assign checked_o    = checked_count;

  // Crossfade the two colours, then combine each channel pair by the mode.
  function automatic blend_rsp_t predict_blend_colour(blend_req_t req);
    logic [ChanW-1:0] first_c [NumChan];
    logic [ChanW-1:0] second_c[NumChan];
    logic [ChanW-1:0] mixed   [NumChan];
    bit [63:0]        scale;
    bit [63:0]        a;
    bit [63:0]        b;
    bit [63:0]        wide;
    blend_rsp_t       colour;
    int               ch;
    first_c  = '{req.first_red, req.first_green, req.first_blue};
    second_c = '{req.second_red, req.second_green, req.second_blue};
    for (ch = 0; ch < NumChan; ch++) begin
      a = 64'(first_c[ch]);
      b = 64'(second_c[ch]);
      // The upper half of the factor fades the first colour, the lower half the second.
      if (req.mix_factor >= MixMid) begin
        scale = ChanTop - 2 * (64'(req.mix_factor) - HalfTop);
        a     = (scale * a) >> 16;
      end else begin
        b = ((64'(req.mix_factor) << 1) * b) >> 16;
      end
      case (req.op)
        OP_ADD:     wide = a + b;
        OP_SUB:     wide = ChanTop - a - b;
        OP_OVERLAY: begin
          if (a < HalfTop) begin
            wide = (2 * a * b) / ChanTop;
          end else begin
            wide = ChanTop - (2 * (ChanTop - a) * (ChanTop - b)) / ChanTop;
          end
        end
        OP_SCREEN:  wide = ChanTop - (((ChanTop - a) * (ChanTop - b)) >> 16);
        OP_AVERAGE: wide = (a + b) >> 1;
        default:    wide = '0;
      endcase
      mixed[ch] = wide[ChanW-1:0];
    end
    colour.out_red   = mixed[0];
    colour.out_green = mixed[1];
    colour.out_blue  = mixed[2];
    return colour;
  endfunction

  // Predict on every accepted request and compare every accepted colour.
  always @(posedge clk_i or negedge rst_ni) begin
    blend_rsp_t want;
    if (!rst_ni) begin
      expected_colour_q.delete();
      fail_count    = 0;
      checked_count = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_colour_q.push_back(predict_blend_colour(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_colour_q.size() == 0) begin
          $display("%0t: colour transaction %h arrived with no request outstanding",
                   $time, out_data_i);
          fail_count++;
        end else begin
          want = expected_colour_q.pop_front();
          checked_count++;
          for (int ch = 0; ch < NumChan; ch++) begin
            if (want[(NumChan-ch)*ChanW-1 -: ChanW] !== out_data_i[(NumChan-ch)*ChanW-1 -: ChanW])
            begin
              $display("%0t: %s expected %h actual %h", $time, chan_name[ch],
                       want[(NumChan-ch)*ChanW-1 -: ChanW],
                       out_data_i[(NumChan-ch)*ChanW-1 -: ChanW]);
              fail_count++;
            end
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rbm_pkg::*;

  localparam logic [ChanW-1:0] Full    = ChanMax;
  localparam logic [ChanW-1:0] MixLow  = 16'd32767;
  localparam logic [ChanW-1:0] MixHigh = 16'd32768;
  localparam logic [OpW-1:0]   OpTop   = {OpW{1'b1}};
  localparam int unsigned      PhaseItems = 440;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  blend_req_t  in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  blend_rsp_t  out_data_o;
  logic        in_fire_q;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned sent_count;
  int unsigned unused_count;

  rgb48_blend_mode_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  rgb48_blend_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Remember whether the request channel moved a transaction at the last edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fire_q <= 1'b0;
    end else begin
      in_fire_q <= in_valid_i && in_ready_o;
    end
  end

  // The colour receiver stalls at random according to the current phase.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic blend_req_t make_req(logic [OpW-1:0] op,
                                          logic [ChanW-1:0] fr, logic [ChanW-1:0] fg,
                                          logic [ChanW-1:0] fb, logic [ChanW-1:0] sr,
                                          logic [ChanW-1:0] sg, logic [ChanW-1:0] sb,
                                          logic [ChanW-1:0] mix);
    blend_req_t req;
    req.op           = op;
    req.first_red    = fr;
    req.first_green  = fg;
    req.first_blue   = fb;
    req.second_red   = sr;
    req.second_green = sg;
    req.second_blue  = sb;
    req.mix_factor   = mix;
    return req;
  endfunction

  // Channel values lean on the extremes and the overlay threshold.
  function automatic logic [ChanW-1:0] rand_chan();
    case ($urandom_range(7))
      0:       return '0;
      1:       return Full;
      2:       return MixLow;
      3:       return MixHigh;
      default: return ChanW'($urandom_range(Full));
    endcase
  endfunction

  function automatic blend_req_t rand_req();
    logic [OpW-1:0] op;
    if ($urandom_range(15) == 0) begin
      op = OpW'($urandom_range(OpTop, OP_AVERAGE + 1));
    end else begin
      op = OpW'($urandom_range(OP_AVERAGE));
    end
    return make_req(op, rand_chan(), rand_chan(), rand_chan(),
                    rand_chan(), rand_chan(), rand_chan(), rand_chan());
  endfunction

  // Offer one request, idling first if the phase asks, and return once it is taken.
  task automatic send_blend(input blend_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    sent_count++;
    if (req.op > OP_AVERAGE) begin
      unused_count++;
    end
    do begin
      @(negedge clk_i);
    end while (!in_fire_q);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PhaseItems) send_blend(rand_req());
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sent_count     = 0;
    unused_count   = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Every mode code, the unused ones too, on full-scale colours.
    for (int m = 0; m <= OpTop; m++) begin
      send_blend(make_req(OpW'(m), Full, Full, Full, Full, Full, Full, MixLow));
    end
    send_blend(make_req(OP_ADD, '0, '0, '0, '0, '0, '0, '0));
    send_blend(make_req(OP_SUB, Full, Full, Full, Full, Full, Full, Full));
    // Overlay either side of its threshold, with the second colour almost untouched.
    send_blend(make_req(OP_OVERLAY, MixLow, MixLow, MixLow, 16'd40000, Full, '0, MixLow));
    send_blend(make_req(OP_OVERLAY, MixHigh, MixHigh, MixHigh, 16'd40000, Full, '0, MixLow));
    // Factor extremes and both sides of the midpoint.
    send_blend(make_req(OP_OVERLAY, 16'h1234, Full, MixHigh, Full, 16'h0001, MixLow, '0));
    send_blend(make_req(OP_SCREEN, 16'h1234, Full, MixHigh, Full, 16'h0001, MixLow, Full));
    send_blend(make_req(OP_SCREEN, 16'hBEEF, 16'h00FF, Full, 16'hFF00, Full, '0, MixHigh));
    send_blend(make_req(OP_OVERLAY, 16'hBEEF, 16'h00FF, Full, 16'hFF00, Full, '0, MixLow));
    send_blend(make_req(OP_AVERAGE, 16'hAAAA, 16'h5555, Full, 16'h5555, 16'hAAAA, Full,
                        MixLow));
    send_blend(make_req(OP_SUB, 16'hAAAA, 16'h5555, '0, 16'h5555, 16'hAAAA, Full, 16'hAAAA));
    send_blend(make_req(OP_ADD, Full, MixHigh, 16'h0001, Full, MixHigh, 16'h0001, MixLow));

    // Random traffic through each handshake pressure pattern.
    run_phase(0, 0);
    run_phase(66, 0);
    run_phase(0, 66);
    run_phase(20, 20);

    in_valid_i     <= 1'b0;
    recv_stall_pct = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Sent %0d blend requests (%0d on unused mode codes) through four pressure phases;",
             sent_count, unused_count);
    $display("%0d blended colours were compared against the prediction.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rbm_pkg.sv
sv/rbm_xfade.sv
sv/rbm_mode_mul.sv
sv/rbm_resolve.sv
sv/rgb48_blend_mode_unit.sv
tb/sv/rgb48_blend_checker.sv
tb/sv/tb_top.sv
